>>> rtl/core/ggbm_pkg.sv
// Shared types, widths and helper functions of the grouped grid block mapper.
// Used by the setup sequencer, the pipelined divider and the top level.
package ggbm_pkg;

  localparam int unsigned IdW      = 31;
  localparam int unsigned NcW      = 5;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned MnW      = 32;
  localparam int unsigned GridW    = 48;
  localparam int unsigned DivNumW  = 37;
  localparam int unsigned DivDenW  = 32;
  localparam int unsigned SetDenW  = 37;
  localparam int unsigned SetCntW  = 6;

  typedef enum logic [CfgIdxW-1:0] {
    CfgNumChiplets = 3'd0,
    CfgGroupSize   = 3'd1,
    CfgBatchBlocks = 3'd2,
    CfgMTiles      = 3'd3,
    CfgNTiles      = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [NcW-1:0]  num_chiplets;
    logic [CfgW-1:0] group_size;
    logic [CfgW-1:0] batch_blocks;
    logic [CfgW-1:0] m_tiles;
    logic [CfgW-1:0] n_tiles;
  } cfg_t;

  typedef struct packed {
    logic              remap_on;
    logic [NcW-1:0]    nc;
    logic [CfgW-1:0]   gs;
    logic [CfgW-1:0]   m_tiles;
    logic [MnW-1:0]    mn;
    logic [GridW-1:0]  grid;
    logic [MnW-1:0]    chunk;
    logic [GridW-1:0]  limit;
    logic [MnW-1:0]    band_size;
  } derived_t;

  typedef struct packed {
    logic             oor;
    logic             remap_en;
    logic [IdW-1:0]   id;
    logic [NcW-1:0]   idnc;
    logic [MnW-1:0]   rem2;
    logic [CfgW-1:0]  g;
    logic [MnW-1:0]   r;
    logic [MnW-1:0]   rem4;
    logic [CfgW-1:0]  first_m;
  } side_t;

  typedef struct packed {
    logic [DivDenW-1:0] rem;
    logic [DivNumW-1:0] nq;
  } div_acc_t;

  // One restoring division step: shift in the next dividend bit and subtract if it fits.
  function automatic div_acc_t div_step(div_acc_t a, logic [DivDenW-1:0] den);
    logic [DivDenW:0] t;
    div_acc_t         r;
    t    = {a.rem, a.nq[DivNumW-1]};
    r.nq = {a.nq[DivNumW-2:0], 1'b0};
    if (t >= {1'b0, den}) begin
      r.rem   = DivDenW'(t - {1'b0, den});
      r.nq[0] = 1'b1;
    end else begin
      r.rem = t[DivDenW-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/ggbm_div.sv
// Fully pipelined restoring divider, one quotient bit per register stage.
// Carries a valid bit and the item's side data along; depends on ggbm_pkg.
module ggbm_div import ggbm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [DivDenW-1:0] den_i,
  input  side_t              side_i,
  output logic               valid_o,
  output logic [DivNumW-1:0] quot_o,
  output logic [DivDenW-1:0] rem_o,
  output side_t              side_o
);

  logic [DivNumW-1:0] valid_q;
  div_acc_t           acc_q  [DivNumW];
  logic [DivDenW-1:0] den_q  [DivNumW];
  side_t              side_q [DivNumW];
  div_acc_t           acc_in;

  assign acc_in = '{rem: '0, nq: num_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[DivNumW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q[0]  <= div_step(acc_in, den_i);
    den_q[0]  <= den_i;
    side_q[0] <= side_i;
    for (int k = 1; k < DivNumW; k++) begin
      acc_q[k]  <= div_step(acc_q[k-1], den_q[k-1]);
      den_q[k]  <= den_q[k-1];
      side_q[k] <= side_q[k-1];
    end
  end

  assign valid_o = valid_q[DivNumW-1];
  assign quot_o  = acc_q[DivNumW-1].nq;
  assign rem_o   = acc_q[DivNumW-1].rem;
  assign side_o  = side_q[DivNumW-1];

endmodule

>>> rtl/core/ggbm_setup.sv
// Setup sequencer: derives grid, remap chunk, remap limit and band size from the
// configuration after every write, with one shared bit-serial divider. Uses ggbm_pkg.
module ggbm_setup import ggbm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  cfg_t     cfg_i,
  output derived_t drv_o,
  output logic     busy_o
);

  typedef enum logic [7:0] {
    SetIdle  = 8'b0000_0001,
    SetProd  = 8'b0000_0010,
    SetGrid  = 8'b0000_0100,
    SetPcDiv = 8'b0000_1000,
    SetChunk = 8'b0001_0000,
    SetSpan  = 8'b0010_0000,
    SetLDiv  = 8'b0100_0000,
    SetLim   = 8'b1000_0000
  } set_state_e;

  set_state_e           state_q, state_d;
  derived_t             drv_q, drv_d;
  logic [SetCntW-1:0]   cnt_q, cnt_d;
  logic [GridW-1:0]     dq_q, dq_d;
  logic [SetDenW-1:0]   dr_q, dr_d;
  logic [SetDenW-1:0]   dden_q, dden_d;
  logic [SetDenW:0]     trial;
  logic [GridW-1:0]     grid_prod;
  logic [GridW-1:0]     pc_min;
  logic [MnW-1:0]       gs_sq;
  logic [SetDenW-1:0]   span;

  assign trial     = {dr_q, dq_q[GridW-1]};
  assign grid_prod = GridW'(cfg_i.batch_blocks) * GridW'(drv_q.mn);
  assign pc_min    = (dq_q == '0) ? GridW'(1) : dq_q;
  assign gs_sq     = MnW'(drv_q.gs) * MnW'(drv_q.gs);
  assign span      = SetDenW'(drv_q.nc) * SetDenW'(drv_q.chunk);

  always_comb begin
    state_d = state_q;
    drv_d   = drv_q;
    cnt_d   = cnt_q;
    dq_d    = dq_q;
    dr_d    = dr_q;
    dden_d  = dden_q;
    unique case (state_q)
      SetIdle: ;
      SetProd: begin
        drv_d.remap_on  = cfg_i.num_chiplets > NcW'(1);
        drv_d.nc        = (cfg_i.num_chiplets == '0) ? NcW'(1) : cfg_i.num_chiplets;
        drv_d.gs        = (cfg_i.group_size == '0) ? CfgW'(1) : cfg_i.group_size;
        drv_d.m_tiles   = cfg_i.m_tiles;
        drv_d.mn        = MnW'(cfg_i.m_tiles) * MnW'(cfg_i.n_tiles);
        drv_d.band_size = MnW'(drv_d.gs) * MnW'(cfg_i.n_tiles);
        state_d         = SetGrid;
      end
      SetGrid: begin
        drv_d.grid = grid_prod;
        dq_d       = grid_prod;
        dr_d       = '0;
        dden_d     = SetDenW'(drv_q.nc);
        cnt_d      = SetCntW'(GridW - 1);
        state_d    = SetPcDiv;
      end
      SetPcDiv, SetLDiv: begin
        dq_d = {dq_q[GridW-2:0], 1'b0};
        if (trial >= {1'b0, dden_q}) begin
          dr_d     = SetDenW'(trial - {1'b0, dden_q});
          dq_d[0]  = 1'b1;
        end else begin
          dr_d = trial[SetDenW-1:0];
        end
        cnt_d = cnt_q - SetCntW'(1);
        if (cnt_q == '0) begin
          state_d = (state_q == SetPcDiv) ? SetChunk : SetLim;
        end
      end
      SetChunk: begin
        drv_d.chunk = (GridW'(gs_sq) < pc_min) ? gs_sq : pc_min[MnW-1:0];
        state_d     = SetSpan;
      end
      SetSpan: begin
        dq_d    = drv_q.grid;
        dr_d    = '0;
        dden_d  = span;
        cnt_d   = SetCntW'(GridW - 1);
        state_d = SetLDiv;
      end
      SetLim: begin
        drv_d.limit = drv_q.grid - GridW'(dr_q);
        state_d     = SetIdle;
      end
      default: state_d = SetIdle;
    endcase
    if (cfg_we_i) begin
      state_d = SetProd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SetIdle;
      drv_q   <= '{remap_on: 1'b0, nc: NcW'(1), gs: CfgW'(1), m_tiles: CfgW'(1),
                   mn: MnW'(1), grid: GridW'(1), chunk: MnW'(1), limit: GridW'(1),
                   band_size: MnW'(1)};
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      drv_q   <= drv_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q   <= dq_d;
    dr_q   <= dr_d;
    dden_q <= dden_d;
  end

  assign drv_o  = drv_q;
  assign busy_o = (state_q != SetIdle);

endmodule

>>> rtl/core/grouped_grid_block_mapper.sv
// Top level of the grouped grid block mapper: configuration registers and the item pipeline.
// Depends on ggbm_pkg, ggbm_setup and ggbm_div.
//
// Usage: write the five configuration registers through cfg_we_i, cfg_idx_i and
// cfg_data_i. After each write the block raises busy_o while the setup sequencer
// derives the grid size, remap chunk, remap limit and band size
// with its bit-serial divider. An item is taken at a clock edge with start_i high
// and busy_o low; items may follow every cycle, so throughput is one item per cycle.
// Each item passes the input register, six pipelined 37-stage dividers (the last
// two side by side), the m1, m2, b and c registers and the output register, in
// which done_o is high with the result on the output ports. done_o is high for
// exactly one cycle per item and the receiver must take it then; nothing stalls.
// Reset clears all valid bits, returns every configuration register to 1 and
// leaves the block idle with the matching derived values, so no setup pass follows reset.
module grouped_grid_block_mapper import ggbm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               start_i,
  input  logic [IdW-1:0]     block_id_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [CfgW-1:0]    batch_index_o,
  output logic [CfgW-1:0]    m_index_o,
  output logic [CfgW-1:0]    n_index_o,
  output logic               out_of_range_o
);

  cfg_t     cfg_q;
  derived_t drv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{num_chiplets: NcW'(1), group_size: CfgW'(1), batch_blocks: CfgW'(1),
                 m_tiles: CfgW'(1), n_tiles: CfgW'(1)};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgNumChiplets: cfg_q.num_chiplets <= cfg_data_i[NcW-1:0];
        CfgGroupSize:   cfg_q.group_size   <= cfg_data_i;
        CfgBatchBlocks: cfg_q.batch_blocks <= cfg_data_i;
        CfgMTiles:      cfg_q.m_tiles      <= cfg_data_i;
        CfgNTiles:      cfg_q.n_tiles      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ggbm_setup u_setup (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_we_i (cfg_we_i),
    .cfg_i    (cfg_q),
    .drv_o    (drv),
    .busy_o   (busy_o)
  );

  // Input register and range check.
  logic           s0_valid_q;
  logic [IdW-1:0] s0_id_q;
  side_t          side0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s0_id_q <= block_id_i;
    end
  end

  always_comb begin
    side0          = '0;
    side0.id       = s0_id_q;
    side0.oor      = GridW'(s0_id_q) >= drv.grid;
    side0.remap_en = drv.remap_on && (GridW'(s0_id_q) <= drv.limit);
  end

  // Chiplet remap: id / nc, then (id / nc) % chunk.
  logic               v1, v2;
  logic [DivNumW-1:0] q1;
  logic [DivDenW-1:0] r1, r2;
  side_t              side1, side1m, side2, side2m;

  ggbm_div u_div_nc (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (s0_valid_q),
    .num_i (DivNumW'(s0_id_q)), .den_i (DivDenW'(drv.nc)), .side_i (side0),
    .valid_o (v1), .quot_o (q1), .rem_o (r1), .side_o (side1)
  );

  always_comb begin
    side1m      = side1;
    side1m.idnc = r1[NcW-1:0];
  end

  ggbm_div u_div_chunk (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (v1),
    .num_i (q1), .den_i (drv.chunk), .side_i (side1m),
    .valid_o (v2), .quot_o (), .rem_o (r2), .side_o (side2)
  );

  always_comb begin
    side2m      = side2;
    side2m.rem2 = r2;
  end

  logic               m1_valid_q, m2_valid_q;
  side_t              m1_side_q, m2_side_q;
  logic [DivNumW-1:0] m1_p1_q, m1_p2_q, m2_id_q, remap_id;

  assign remap_id = m1_side_q.remap_en
                  ? DivNumW'(m1_side_q.id) + DivNumW'(m1_side_q.rem2) + m1_p2_q
                    - m1_p1_q - DivNumW'(m1_side_q.idnc)
                  : DivNumW'(m1_side_q.id);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_valid_q <= 1'b0;
      m2_valid_q <= 1'b0;
    end else begin
      m1_valid_q <= v2;
      m2_valid_q <= m1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_side_q <= side2m;
    m1_p1_q   <= DivNumW'(drv.nc) * DivNumW'(r2);
    m1_p2_q   <= DivNumW'(side2.idnc) * DivNumW'(drv.chunk);
    m2_side_q <= m1_side_q;
    m2_id_q   <= remap_id;
  end

  // Split by m*n, then by band size.
  logic               v3, v4;
  logic [DivNumW-1:0] q3, q4;
  logic [DivDenW-1:0] r3, r4;
  side_t              side3, side3m, side4, side4m;

  ggbm_div u_div_mn (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (m2_valid_q),
    .num_i (m2_id_q), .den_i (drv.mn), .side_i (m2_side_q),
    .valid_o (v3), .quot_o (q3), .rem_o (r3), .side_o (side3)
  );

  always_comb begin
    side3m   = side3;
    side3m.g = q3[CfgW-1:0];
    side3m.r = r3;
  end

  ggbm_div u_div_band (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (v3),
    .num_i (DivNumW'(r3)), .den_i (drv.band_size), .side_i (side3m),
    .valid_o (v4), .quot_o (q4), .rem_o (r4), .side_o (side4)
  );

  logic             b_valid_q, c_valid_q;
  side_t            b_side_q, c_side_q, side_bm;
  logic [GridW-1:0] b_fm_q;
  logic [CfgW-1:0]  c_rows_q, rows;
  logic [CfgW-1:0]  m_left;

  always_comb begin
    side4m      = side4;
    side4m.rem4 = r4;
  end

  always_comb begin
    side_bm         = b_side_q;
    side_bm.first_m = b_fm_q[CfgW-1:0];
  end

  assign m_left = drv.m_tiles - b_fm_q[CfgW-1:0];
  assign rows   = (b_fm_q < GridW'(drv.m_tiles))
                ? ((m_left < drv.gs) ? m_left : drv.gs)
                : CfgW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      b_valid_q <= v4;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_side_q <= side4m;
    b_fm_q   <= GridW'(q4[MnW-1:0]) * GridW'(drv.gs);
    c_side_q <= side_bm;
    c_rows_q <= rows;
  end

  // Position inside the band.
  logic               v5;
  logic [DivNumW-1:0] q5;
  logic [DivDenW-1:0] r5;
  side_t              side5;

  ggbm_div u_div_mrow (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (c_valid_q),
    .num_i (DivNumW'(c_side_q.r)), .den_i (DivDenW'(c_rows_q)), .side_i (c_side_q),
    .valid_o (v5), .quot_o (), .rem_o (r5), .side_o (side5)
  );

  ggbm_div u_div_ncol (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (c_valid_q),
    .num_i (DivNumW'(c_side_q.rem4)), .den_i (DivDenW'(c_rows_q)), .side_i (c_side_q),
    .valid_o (), .quot_o (q5), .rem_o (), .side_o ()
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= v5;
    end
  end

  always_ff @(posedge clk_i) begin
    out_of_range_o <= side5.oor;
    batch_index_o  <= side5.oor ? '0 : side5.g;
    m_index_o      <= side5.oor ? '0 : side5.first_m + r5[CfgW-1:0];
    n_index_o      <= side5.oor ? '0 : q5[CfgW-1:0];
  end

endmodule

>>> tb/tb_grouped_grid_block_mapper.sv
// Testbench of the grouped grid block mapper: directed and random block ids under several
// register settings, each result checked against a built-in predictor. Depends on ggbm_pkg.
`timescale 1ns / 100ps

module tb_grouped_grid_block_mapper;
  import ggbm_pkg::*;

  typedef struct packed {
    logic [CfgW-1:0] batch_index;
    logic [CfgW-1:0] m_index;
    logic [CfgW-1:0] n_index;
    logic            out_of_range;
  } tile_t;

  class tile_scoreboard;
    longint unsigned nc, gs, bb, mt, nt;
    tile_t           pending[$];
    int              errors;

    function new();
      nc = 1; gs = 1; bb = 1; mt = 1; nt = 1; errors = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        CfgNumChiplets: nc = data[NcW-1:0];
        CfgGroupSize:   gs = data;
        CfgBatchBlocks: bb = data;
        CfgMTiles:      mt = data;
        CfgNTiles:      nt = data;
        default: ;
      endcase
    endfunction

    function longint unsigned grid_size();
      return bb * mt * nt;
    endfunction

    function tile_t map_id(logic [IdW-1:0] block_id);
      longint unsigned id, g2, mn, grid, per, chunk, span, lim, loc;
      longint unsigned r, band_size, first_m, rows;
      tile_t           t;
      id   = block_id;
      g2   = (gs == 0) ? 1 : gs;
      mn   = mt * nt;
      grid = bb * mn;
      t    = '0;
      if (id >= grid || mn == 0) begin
        t.out_of_range = 1'b1;
        return t;
      end
      if (nc > 1) begin
        per   = grid / nc;
        if (per < 1) per = 1;
        chunk = (g2 * g2 < per) ? g2 * g2 : per;
        span  = nc * chunk;
        lim   = (grid / span) * span;
        if (id <= lim) begin
          loc = id / nc;
          id  = (loc / chunk) * span + (id % nc) * chunk + (loc % chunk);
        end
      end
      r         = id % mn;
      band_size = g2 * nt;
      first_m   = (r / band_size) * g2;
      rows      = (first_m < mt) ? ((mt - first_m < g2) ? mt - first_m : g2) : 1;
      t.batch_index = CfgW'(id / mn);
      t.m_index     = CfgW'(first_m + r % rows);
      t.n_index     = CfgW'((r % band_size) / rows);
      return t;
    endfunction

    function void note_item(logic [IdW-1:0] block_id);
      pending.push_back(map_id(block_id));
    endfunction

    function void check_result(tile_t got);
      tile_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected %p actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i, rst_ni, cfg_we_i, start_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;
  logic [IdW-1:0]     block_id_i;
  logic               busy_o, done_o, out_of_range_o;
  logic [CfgW-1:0]    batch_index_o, m_index_o, n_index_o;

  tile_scoreboard sb = new();
  int             idle_pct;

  grouped_grid_block_mapper u_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_item(block_id_i);
      if (done_o) sb.check_result({batch_index_o, m_index_o, n_index_o, out_of_range_o});
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, data);
    repeat (2) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic configure(int nc, int gs, int bb, int mt, int nt);
    write_reg(CfgNumChiplets, CfgW'(nc));
    write_reg(CfgGroupSize, CfgW'(gs));
    write_reg(CfgBatchBlocks, CfgW'(bb));
    write_reg(CfgMTiles, CfgW'(mt));
    write_reg(CfgNTiles, CfgW'(nt));
    if ($urandom_range(1, 0)) write_reg(CfgIdxW'($urandom_range(7, 5)), CfgW'($urandom));
  endtask

  task automatic send_item(logic [IdW-1:0] id);
    start_i    <= 1'b1;
    block_id_i <= id;
    do @(posedge clk_i); while (busy_o);
    if ($urandom_range(99, 0) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    if (start_i) start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [IdW-1:0] pick_id();
    longint unsigned grid, span, raw;
    grid = sb.grid_size();
    raw  = {$urandom, $urandom};
    span = (grid + 3 < 64'h8000_0000) ? grid + 3 : 64'h8000_0000;
    case ($urandom_range(9, 0))
      0:       return IdW'($urandom);
      1:       return IdW'(grid + $urandom_range(2, 0) - 1);
      default: return IdW'(raw % span);
    endcase
  endfunction

  task automatic run_phase(int nc, int gs, int bb, int mt, int nt, int count);
    longint unsigned grid;
    configure(nc, gs, bb, mt, nt);
    grid = sb.grid_size();
    send_item('0);
    send_item('1);
    send_item(IdW'(grid));
    send_item(IdW'(grid - 1));
    send_item(IdW'(grid / 2));
    repeat (count) send_item(pick_id());
    drain();
  endtask

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    start_i    = 1'b0;
    block_id_i = '0;
    idle_pct   = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < 14; i++) idle_pct = 0;
    run_phase(1, 1, 1, 1, 1, 20);
    run_phase(16, 4, 3, 5, 7, 40);
    idle_pct = 70;
    run_phase(31, 65535, 65535, 65535, 65535, 20);
    run_phase(0, 0, 2, 3, 4, 30);
    idle_pct = 18;
    run_phase(4, 2, 0, 5, 5, 10);
    run_phase(5, 3, 2, 9, 1, 40);
    run_phase(3, 2, 1, 65535, 3, 30);
    for (int p = 0; p < 10; p++) begin
      idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 70 : 18);
      run_phase($urandom_range(31, 0), $urandom_range(6, 0), $urandom_range(5, 1),
                $urandom_range(40, 1), $urandom_range(40, 1), 40);
    end
    repeat (250) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
